>>> sv/rm5_pkg.sv
// Shared constants for the five-sample running median filter.
`default_nettype none

package rm5_pkg;

    // Timestamp width.
    localparam int unsigned TIME_W   = 31;
    // Past samples held in the cell row.
    localparam int unsigned PAST_LEN = 4;
    // Samples in one window, newest included.
    localparam int unsigned WIN_LEN  = PAST_LEN + 1;
    // Rank of the median in sorted order, counted from zero.
    localparam int unsigned MED_RANK = WIN_LEN / 2;
    // Width of the fill counter, enough to hold PAST_LEN.
    localparam int unsigned FILL_W   = $clog2(PAST_LEN + 1);
    // Width of a rank count, enough to hold WIN_LEN - 1.
    localparam int unsigned RANK_W   = $clog2(WIN_LEN);

    typedef logic [TIME_W-1:0] time_t;
    typedef logic [FILL_W-1:0] fill_t;
    typedef logic [RANK_W-1:0] rank_t;

endpackage : rm5_pkg

`default_nettype wire

>>> sv/rm5_cell.sv
// One cell of the delay row: holds one past value and its timestamp.
`default_nettype none

module rm5_cell #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          shift_en,
    input  wire logic signed [VALUE_WIDTH-1:0] value_in,
    input  wire rm5_pkg::time_t                time_in,
    output logic signed [VALUE_WIDTH-1:0]      value_q,
    output rm5_pkg::time_t                     time_q
);
    import rm5_pkg::*;

    logic signed [VALUE_WIDTH-1:0] value_reg;
    time_t                         time_reg;

    // Take the neighbour's sample on each accepted beat
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            value_reg <= value_in;
            time_reg  <= time_in;
        end
    end

    assign value_q = value_reg;
    assign time_q  = time_reg;

endmodule : rm5_cell

`default_nettype wire

>>> sv/rm5_median.sv
// Rank-select network: picks the third smallest of five signed values.
`default_nettype none

module rm5_median #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  wire logic signed [VALUE_WIDTH-1:0] win [rm5_pkg::WIN_LEN],
    output logic signed [VALUE_WIDTH-1:0]      median
);
    import rm5_pkg::*;

    logic [WIN_LEN-1:0] below [WIN_LEN];
    rank_t              rank  [WIN_LEN];

    // Compare every pair; ties are broken by position so ranks are unique
    always_comb begin
        for (int i = 0; i < WIN_LEN; i++) begin
            for (int j = 0; j < WIN_LEN; j++) begin
                below[i][j] = (win[j] < win[i]) || ((win[j] == win[i]) && (j < i));
            end
        end
    end

    // Count the values below each entry
    always_comb begin
        for (int i = 0; i < WIN_LEN; i++) begin
            rank[i] = '0;
            for (int j = 0; j < WIN_LEN; j++) begin
                rank[i] = rank[i] + rank_t'(below[i][j]);
            end
        end
    end

    // Select the entry whose rank is the middle one
    always_comb begin
        median = '0;
        for (int i = 0; i < WIN_LEN; i++) begin
            if (rank[i] == rank_t'(MED_RANK)) begin
                median = median | win[i];
            end
        end
    end

endmodule : rm5_median

`default_nettype wire

>>> sv/running_median_5_core.sv
// Top level of the five-sample running median filter.
//
//   Channel  Dir  tdata (low bit up)                  tuser
//   s_       in   sample_time, sample_value, pad 0    restart
//   m_       out  centre_time, median_value, pad 0    -
//
// One sample is taken per cycle while s_tready is high; the result for the
// sample that completes its window passes the window register, then the output register.
// Reset clears the fill count and both stage valids; stored samples are
// not cleared. A stall on m_ fills the two stages and then holds s_tready
// low; any empty stage lets a beat in.
`default_nettype none

module running_median_5_core #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // sample_time, sample_value, zero pad
    input  wire logic [((rm5_pkg::TIME_W + VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    // restart
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // centre_time, median_value, zero pad
    output logic [((rm5_pkg::TIME_W + VALUE_WIDTH + 7) / 8) * 8 - 1:0] m_tdata
);
    import rm5_pkg::*;

    localparam int unsigned FIELD_W = TIME_W + VALUE_WIDTH;
    localparam int unsigned DATA_W  = ((FIELD_W + 7) / 8) * 8;

    logic                          s_fire;
    logic                          restart;
    time_t                         sample_time;
    logic signed [VALUE_WIDTH-1:0] sample_value;

    logic signed [VALUE_WIDTH-1:0] cell_value [PAST_LEN+1];
    time_t                         cell_time  [PAST_LEN+1];

    fill_t fill_reg, fill_next, fill_base;
    logic  produce;

    logic                          win_valid_reg;
    logic signed [VALUE_WIDTH-1:0] win_reg [WIN_LEN];
    time_t                         win_time_reg;
    logic                          win_ready;

    logic signed [VALUE_WIDTH-1:0] median;
    logic                          out_valid_reg;
    logic signed [VALUE_WIDTH-1:0] out_value_reg;
    time_t                         out_time_reg;
    logic                          out_ready;

    // Unpack the input beat
    assign restart      = s_tuser;
    assign sample_time  = s_tdata[TIME_W-1:0];
    assign sample_value = s_tdata[FIELD_W-1:TIME_W];

    // Back-pressure, stage by stage
    assign out_ready = !out_valid_reg || m_tready;
    assign win_ready = !win_valid_reg || out_ready;
    assign s_tready  = win_ready;
    assign s_fire    = s_tvalid && s_tready;

    // Feed the newest sample into the head of the cell row
    assign cell_value[0] = sample_value;
    assign cell_time[0]  = sample_time;

    genvar g;
    generate
        for (g = 0; g < PAST_LEN; g++) begin : g_cell
            rm5_cell #(
                .VALUE_WIDTH(VALUE_WIDTH)
            ) u_cell (
                .aclk    (aclk),
                .shift_en(s_fire),
                .value_in(cell_value[g]),
                .time_in (cell_time[g]),
                .value_q (cell_value[g+1]),
                .time_q  (cell_time[g+1])
            );
        end
    endgenerate

    // Count held samples; restart empties the window first
    always_comb begin
        fill_base = restart ? '0 : fill_reg;
        produce   = (fill_base == fill_t'(PAST_LEN));
        fill_next = produce ? fill_base : fill_base + fill_t'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (s_fire) begin
            fill_reg <= fill_next;
        end
    end

    // Window stage: capture the five values and the centre timestamp
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_valid_reg <= 1'b0;
        end else if (win_ready) begin
            win_valid_reg <= s_fire && produce;
        end
    end

    always_ff @(posedge aclk) begin
        if (win_ready && s_fire && produce) begin
            for (int i = 0; i < WIN_LEN; i++) begin
                win_reg[i] <= cell_value[i];
            end
            win_time_reg <= cell_time[2];
        end
    end

    rm5_median #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_median (
        .win   (win_reg),
        .median(median)
    );

    // Output stage: hold the result until the beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= win_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && win_valid_reg) begin
            out_value_reg <= median;
            out_time_reg  <= win_time_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DATA_W'({out_value_reg, out_time_reg});

endmodule : running_median_5_core

`default_nettype wire

>>> sv/rm5_checker.sv
// Port-level checks for the running median core, bound to the top level.
`default_nettype none

module rm5_checker #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_tvalid,
    input wire logic s_tready,
    input wire logic [((rm5_pkg::TIME_W + VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    input wire logic s_tuser,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic [((rm5_pkg::TIME_W + VALUE_WIDTH + 7) / 8) * 8 - 1:0] m_tdata
);

    // No result may appear straight out of reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat offered right after reset");

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // A waiting sample beat holds its payload and restart flag
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("waiting sample beat changed");

    // With the output stage empty the input side must be open
    a_in_open: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked while output is empty");

    // A beat taken at the output leaves room for a new sample
    a_drain_open: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |-> s_tready)
        else $error("input blocked while result beat drains");

endmodule : rm5_checker

bind running_median_5_core rm5_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
) u_rm5_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

`default_nettype wire
